/* sv/mp2_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mp2_pkg
// Shared types and constants of the streaming 2-D max pooling block:
// register indexes, controller states and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package mp2_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 11;
	localparam int WIN_FIELD_W = 4;

	localparam int RST_IN_WIDTH      = 28;
	localparam int RST_IN_HEIGHT     = 28;
	localparam int RST_WINDOW_WIDTH  = 2;
	localparam int RST_WINDOW_HEIGHT = 2;
	localparam int RST_STEP          = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_IN_WIDTH      = 3'd0,
		REG_IN_HEIGHT     = 3'd1,
		REG_WINDOW_WIDTH  = 3'd2,
		REG_WINDOW_HEIGHT = 3'd3,
		REG_STEP          = 3'd4
	} mp2_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_HOLD
	} mp2_state_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
		logic rd_first;
		logic load_out;
		logic out_last;
	} mp2_cmd_t;

endpackage
`default_nettype wire

/* sv/mp2_cfg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mp2_cfg
// Configuration registers. Values saturate on write (window/step: low 4 bits),
// zero counts as one, and every write to a known register restarts the plane.
// ----------------------------------------------------------------------------
module mp2_cfg
	import mp2_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_WINDOW = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [CFG_INDEX_W-1:0]       cfg_index,
	input  wire logic [CFG_DATA_W-1:0]        cfg_data,
	output logic [$clog2(MAX_WIDTH+1)-1:0]    in_width,
	output logic [$clog2(MAX_WIDTH+1)-1:0]    in_height,
	output logic [$clog2(MAX_WINDOW+1)-1:0]   window_width,
	output logic [$clog2(MAX_WINDOW+1)-1:0]   window_height,
	output logic [$clog2(MAX_WINDOW+1)-1:0]   step,
	output logic                              cfg_clear
);

	localparam int DIM_W = $clog2(MAX_WIDTH+1);
	localparam int WIN_W = $clog2(MAX_WINDOW+1);

	logic [DIM_W-1:0] in_width_q;
	logic [DIM_W-1:0] in_height_q;
	logic [WIN_W-1:0] window_width_q;
	logic [WIN_W-1:0] window_height_q;
	logic [WIN_W-1:0] step_q;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > MAX_WIDTH)
			r = DIM_W'(MAX_WIDTH);
		else
			r = DIM_W'(v);
		return r;
	endfunction

	function automatic logic [WIN_W-1:0] clamp_win(input logic [CFG_DATA_W-1:0] v);
		logic [WIN_FIELD_W-1:0] f;
		logic [WIN_W-1:0]       r;
		f = v[WIN_FIELD_W-1:0];
		if (f == '0)
			r = WIN_W'(1);
		else if (f > MAX_WINDOW)
			r = WIN_W'(MAX_WINDOW);
		else
			r = WIN_W'(f);
		return r;
	endfunction

	always_comb begin
		case (cfg_index)
			REG_IN_WIDTH, REG_IN_HEIGHT, REG_WINDOW_WIDTH,
			REG_WINDOW_HEIGHT, REG_STEP: cfg_clear = cfg_we;
			default: cfg_clear = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q      <= clamp_dim(CFG_DATA_W'(RST_IN_WIDTH));
			in_height_q     <= clamp_dim(CFG_DATA_W'(RST_IN_HEIGHT));
			window_width_q  <= clamp_win(CFG_DATA_W'(RST_WINDOW_WIDTH));
			window_height_q <= clamp_win(CFG_DATA_W'(RST_WINDOW_HEIGHT));
			step_q          <= clamp_win(CFG_DATA_W'(RST_STEP));
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IN_WIDTH:      in_width_q      <= clamp_dim(cfg_data);
				REG_IN_HEIGHT:     in_height_q     <= clamp_dim(cfg_data);
				REG_WINDOW_WIDTH:  window_width_q  <= clamp_win(cfg_data);
				REG_WINDOW_HEIGHT: window_height_q <= clamp_win(cfg_data);
				REG_STEP:          step_q          <= clamp_win(cfg_data);
				default: ;
			endcase
		end
	end

	assign in_width      = in_width_q;
	assign in_height     = in_height_q;
	assign window_width  = window_width_q;
	assign window_height = window_height_q;
	assign step          = step_q;

endmodule
`default_nettype wire

/* sv/mp2_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mp2_ctrl
// Controller: row and column position, stride phases, window detection and
// the sequencing of the column reads for one window.
// ----------------------------------------------------------------------------
module mp2_ctrl
	import mp2_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_WINDOW = 8
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic                               cfg_clear,
	input  wire logic [$clog2(MAX_WIDTH+1)-1:0]     in_width,
	input  wire logic [$clog2(MAX_WIDTH+1)-1:0]     in_height,
	input  wire logic [$clog2(MAX_WINDOW+1)-1:0]    window_width,
	input  wire logic [$clog2(MAX_WINDOW+1)-1:0]    window_height,
	input  wire logic [$clog2(MAX_WINDOW+1)-1:0]    step,
	input  wire logic                               out_free,
	output mp2_cmd_t                                cmd,
	output logic [$clog2(MAX_WIDTH)-1:0]            wr_col,
	output logic [$clog2(MAX_WINDOW)-1:0]           wr_slot,
	output logic [$clog2(MAX_WIDTH)-1:0]            rd_col,
	output logic [$clog2(MAX_WINDOW)-1:0]           top_slot
);

	localparam int CNT_W  = $clog2(MAX_WIDTH);
	localparam int DIM_W  = $clog2(MAX_WIDTH+1);
	localparam int WIN_W  = $clog2(MAX_WINDOW+1);
	localparam int SLOT_W = $clog2(MAX_WINDOW);
	localparam int SL1_W  = SLOT_W + 1;
	localparam int EXT_W  = ((DIM_W > WIN_W) ? DIM_W : WIN_W) + 1;

	mp2_state_t        state_q, state_nx;
	logic [CNT_W-1:0]  col_q, row_q, rd_col_q;
	logic [SLOT_W-1:0] slot_q, cph_q, rph_q, top_q;
	logic [WIN_W-1:0]  rd_cnt_q;
	logic              first_q, last_q;

	logic [EXT_W-1:0]  col_p1, row_p1, w_x, h_x, ww_x, wh_x, st_x;
	logic              col_ge, row_ge, col_end, row_end, hit, last_pos, accept;
	logic [SLOT_W-1:0] st_m1;
	logic [SL1_W-1:0]  wh_m1, slot_x, top_calc;
	logic [CNT_W-1:0]  c0;

	assign w_x    = EXT_W'(in_width);
	assign h_x    = EXT_W'(in_height);
	assign ww_x   = EXT_W'(window_width);
	assign wh_x   = EXT_W'(window_height);
	assign st_x   = EXT_W'(step);
	assign col_p1 = EXT_W'(col_q) + EXT_W'(1);
	assign row_p1 = EXT_W'(row_q) + EXT_W'(1);

	assign col_ge   = col_p1 >= ww_x;
	assign row_ge   = row_p1 >= wh_x;
	assign col_end  = col_p1 == w_x;
	assign row_end  = row_p1 == h_x;
	assign hit      = col_ge && row_ge && (cph_q == '0) && (rph_q == '0);
	assign last_pos = (EXT_W'(col_q) + st_x >= w_x) && (EXT_W'(row_q) + st_x >= h_x);

	assign st_m1    = SLOT_W'(step - WIN_W'(1));
	assign wh_m1    = SL1_W'(window_height - WIN_W'(1));
	assign slot_x   = SL1_W'(slot_q);
	assign top_calc = (slot_x >= wh_m1) ? slot_x - wh_m1
	                                    : slot_x + SL1_W'(MAX_WINDOW) - wh_m1;
	assign c0       = CNT_W'(col_p1 - ww_x);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx     = state_q;
		cmd.wr_en    = 1'b0;
		cmd.rd_en    = 1'b0;
		cmd.rd_first = first_q;
		cmd.load_out = 1'b0;
		cmd.out_last = last_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.wr_en = 1'b1;
					if (hit)
						state_nx = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				if (rd_cnt_q == WIN_W'(1))
					state_nx = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_nx = ST_HOLD;
			end
			ST_HOLD: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			slot_q   <= '0;
			cph_q    <= '0;
			rph_q    <= '0;
			rd_col_q <= '0;
			rd_cnt_q <= '0;
			top_q    <= '0;
			first_q  <= 1'b0;
			last_q   <= 1'b0;
		end else if (cfg_clear) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
			cph_q  <= '0;
			rph_q  <= '0;
		end else if (accept) begin
			if (col_end) begin
				col_q <= '0;
				cph_q <= '0;
				row_q <= row_end ? '0 : CNT_W'(row_p1);
				if (row_end || !row_ge)
					rph_q <= '0;
				else
					rph_q <= (rph_q == st_m1) ? '0 : rph_q + SLOT_W'(1);
				if (row_end || slot_q == SLOT_W'(MAX_WINDOW-1))
					slot_q <= '0;
				else
					slot_q <= slot_q + SLOT_W'(1);
			end else begin
				col_q <= CNT_W'(col_p1);
				if (!col_ge)
					cph_q <= '0;
				else
					cph_q <= (cph_q == st_m1) ? '0 : cph_q + SLOT_W'(1);
			end
			rd_col_q <= c0;
			rd_cnt_q <= window_width;
			top_q    <= top_calc[SLOT_W-1:0];
			first_q  <= 1'b1;
			last_q   <= last_pos;
		end else if (state_q == ST_READ) begin
			rd_col_q <= rd_col_q + CNT_W'(1);
			rd_cnt_q <= rd_cnt_q - WIN_W'(1);
			first_q  <= 1'b0;
		end
	end

	assign wr_col   = col_q;
	assign wr_slot  = slot_q;
	assign rd_col   = rd_col_q;
	assign top_slot = top_q;

endmodule
`default_nettype wire

/* sv/mp2_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mp2_dp
// Datapath: row store with one word per column and one lane per row slot,
// masked column maximum, running window maximum and the output register.
// ----------------------------------------------------------------------------
module mp2_dp
	import mp2_pkg::*;
#(
	parameter int MAX_WIDTH   = 1024,
	parameter int MAX_WINDOW  = 8,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire mp2_cmd_t                          cmd,
	input  wire logic [SAMPLE_BITS-1:0]            sample,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]      wr_col,
	input  wire logic [$clog2(MAX_WINDOW)-1:0]     wr_slot,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]      rd_col,
	input  wire logic [$clog2(MAX_WINDOW)-1:0]     top_slot,
	input  wire logic [$clog2(MAX_WINDOW+1)-1:0]   window_height,
	input  wire logic                              m_tready,
	output logic                                   out_free,
	output logic                                   m_tvalid,
	output logic [SAMPLE_BITS-1:0]                 pooled,
	output logic                                   m_tlast
);

	localparam int SLOT_W = $clog2(MAX_WINDOW);
	localparam int SL1_W  = SLOT_W + 1;
	localparam int TREE_N = 1 << $clog2(MAX_WINDOW);

	logic [MAX_WINDOW-1:0][SAMPLE_BITS-1:0] mem_q [MAX_WIDTH];
	logic [MAX_WINDOW-1:0][SAMPLE_BITS-1:0] rd_data_s1;
	logic                                   rd_vld_s1, rd_first_s1;

	logic signed [SAMPLE_BITS-1:0] node [2*TREE_N];
	logic signed [SAMPLE_BITS-1:0] col_max, acc_q;
	logic [SAMPLE_BITS-1:0]        out_q;
	logic                          out_vld_q, out_last_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en)
			mem_q[wr_col][wr_slot] <= sample;
		if (cmd.rd_en)
			rd_data_s1 <= mem_q[rd_col];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1   <= 1'b0;
			rd_first_s1 <= 1'b0;
		end else begin
			rd_vld_s1   <= cmd.rd_en;
			rd_first_s1 <= cmd.rd_first;
		end
	end

	always_comb begin
		logic [SL1_W-1:0] d;
		logic [SL1_W-1:0] top_x;
		logic [SL1_W-1:0] j_x;
		top_x = SL1_W'(top_slot);
		for (int j = 0; j < TREE_N; j++) begin
			j_x = SL1_W'(j);
			d   = (j_x >= top_x) ? j_x - top_x : j_x + SL1_W'(MAX_WINDOW) - top_x;
			if (j < MAX_WINDOW && d < SL1_W'(window_height))
				node[TREE_N+j] = rd_data_s1[j % MAX_WINDOW];
			else
				node[TREE_N+j] = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end
		for (int i = TREE_N-1; i >= 1; i--) begin
			node[i] = (node[2*i+1] > node[2*i]) ? node[2*i+1] : node[2*i];
		end
		node[0] = node[1];
		col_max = node[1];
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			if (rd_first_s1 || col_max > acc_q)
				acc_q <= col_max;
		end
		if (cmd.load_out) begin
			out_q      <= acc_q;
			out_last_q <= cmd.out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign out_free = !out_vld_q || m_tready;
	assign m_tvalid = out_vld_q;
	assign pooled   = out_q;
	assign m_tlast  = out_last_q;

endmodule
`default_nettype wire

/* sv/max_pool_2d_stream.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// max_pool_2d_stream
// Streaming 2-D max pooling over raster-ordered planes.
//
//   Channel   Direction  Handshake            Payload
//   s_*       in         s_tvalid/s_tready    s_tdata: sample
//   m_*       out        m_tvalid/m_tready    m_tdata: pooled, m_tlast: last_of_plane
//   cfg_*     in         cfg_we               cfg_index, cfg_data
//
// A sample that completes no window is only written to the row store. One that
// completes a window is followed by READ, DRAIN and HOLD before the next is taken:
// the row store has one read port and one word per column, so the window is read
// one column per cycle. A result waits in the output register while the next samples
// are taken; a completing sample waits in the controller until that register is free.
// After reset the block is ready at once; the row store needs no clearing.
// ----------------------------------------------------------------------------
module max_pool_2d_stream
	import mp2_pkg::*;
#(
	parameter int MAX_WIDTH   = 1024,
	parameter int MAX_WINDOW  = 8,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,  // sample
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]         m_tdata,  // pooled
	output logic                                     m_tlast,
	input  wire logic                                cfg_we,
	input  wire logic [CFG_INDEX_W-1:0]              cfg_index,
	input  wire logic [CFG_DATA_W-1:0]               cfg_data
);

	localparam int TDATA_W = ((SAMPLE_BITS+7)/8)*8;
	localparam int CNT_W   = $clog2(MAX_WIDTH);
	localparam int DIM_W   = $clog2(MAX_WIDTH+1);
	localparam int WIN_W   = $clog2(MAX_WINDOW+1);
	localparam int SLOT_W  = $clog2(MAX_WINDOW);

	logic [DIM_W-1:0]       in_width, in_height;
	logic [WIN_W-1:0]       window_width, window_height, step;
	logic                   cfg_clear;
	logic                   out_free;
	mp2_cmd_t               cmd;
	logic [CNT_W-1:0]       wr_col, rd_col;
	logic [SLOT_W-1:0]      wr_slot, top_slot;
	logic [SAMPLE_BITS-1:0] pooled;

	mp2_cfg #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_WINDOW (MAX_WINDOW)
	) u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_width      (in_width),
		.in_height     (in_height),
		.window_width  (window_width),
		.window_height (window_height),
		.step          (step),
		.cfg_clear     (cfg_clear)
	);

	mp2_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_WINDOW (MAX_WINDOW)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.cfg_clear     (cfg_clear),
		.in_width      (in_width),
		.in_height     (in_height),
		.window_width  (window_width),
		.window_height (window_height),
		.step          (step),
		.out_free      (out_free),
		.cmd           (cmd),
		.wr_col        (wr_col),
		.wr_slot       (wr_slot),
		.rd_col        (rd_col),
		.top_slot      (top_slot)
	);

	mp2_dp #(
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sample        (s_tdata[SAMPLE_BITS-1:0]),
		.wr_col        (wr_col),
		.wr_slot       (wr_slot),
		.rd_col        (rd_col),
		.top_slot      (top_slot),
		.window_height (window_height),
		.m_tready      (m_tready),
		.out_free      (out_free),
		.m_tvalid      (m_tvalid),
		.pooled        (pooled),
		.m_tlast       (m_tlast)
	);

	assign m_tdata = TDATA_W'(pooled);

endmodule
`default_nettype wire
